// File: rtl/mgm_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and round helpers for the Magma block cipher.
// Depends on nothing; every other file of the block uses it.
package mgm_pkg;

    localparam int unsigned KeyWords  = 8;
    localparam int unsigned Rounds    = 32;
    localparam int unsigned RotLeft   = 11;
    localparam int unsigned WordW     = 32;
    localparam int unsigned BlockW    = 64;
    localparam int unsigned KeyIdxW   = 3;
    localparam int unsigned CfgIdxW   = 4;

    // Command codes carried with each block.
    localparam logic CmdEncrypt = 1'b0;
    localparam logic CmdDecrypt = 1'b1;

    typedef logic [WordW-1:0] t_word;
    typedef t_word t_key [KeyWords];

    // Contents of one cell of the round chain.
    typedef struct packed {
        logic  valid;
        logic  cmd;
        t_word left;
        t_word right;
    } t_stage;

    typedef logic [3:0] t_sbox_row [16];
    typedef t_sbox_row t_sbox [8];

    // Box 0 acts on the most significant nibble.
    localparam t_sbox Sbox = '{
        '{4'd1,  4'd7,  4'd14, 4'd13, 4'd0,  4'd5,  4'd8,  4'd3,
          4'd4,  4'd15, 4'd10, 4'd6,  4'd9,  4'd12, 4'd11, 4'd2},
        '{4'd8,  4'd14, 4'd2,  4'd5,  4'd6,  4'd9,  4'd1,  4'd12,
          4'd15, 4'd4,  4'd11, 4'd0,  4'd13, 4'd10, 4'd3,  4'd7},
        '{4'd5,  4'd13, 4'd15, 4'd6,  4'd9,  4'd2,  4'd12, 4'd10,
          4'd11, 4'd7,  4'd8,  4'd1,  4'd4,  4'd3,  4'd14, 4'd0},
        '{4'd7,  4'd15, 4'd5,  4'd10, 4'd8,  4'd1,  4'd6,  4'd13,
          4'd0,  4'd9,  4'd3,  4'd14, 4'd11, 4'd4,  4'd2,  4'd12},
        '{4'd12, 4'd8,  4'd2,  4'd1,  4'd13, 4'd4,  4'd15, 4'd6,
          4'd7,  4'd0,  4'd10, 4'd5,  4'd3,  4'd14, 4'd9,  4'd11},
        '{4'd11, 4'd3,  4'd5,  4'd8,  4'd2,  4'd15, 4'd10, 4'd13,
          4'd14, 4'd1,  4'd7,  4'd4,  4'd12, 4'd9,  4'd6,  4'd0},
        '{4'd6,  4'd8,  4'd2,  4'd3,  4'd9,  4'd10, 4'd5,  4'd12,
          4'd1,  4'd14, 4'd4,  4'd7,  4'd11, 4'd13, 4'd0,  4'd15},
        '{4'd12, 4'd4,  4'd6,  4'd2,  4'd10, 4'd5,  4'd11, 4'd9,
          4'd14, 4'd8,  4'd13, 4'd7,  4'd0,  4'd3,  4'd15, 4'd1}
    };

    // Eight parallel 4-bit substitutions.
    function automatic t_word sbox_layer(input t_word v);
        t_word r;
        r = '0;
        for (int b = 0; b < 8; b++) begin
            r[4*(7-b) +: 4] = Sbox[b][v[4*(7-b) +: 4]];
        end
        return r;
    endfunction

    // Round function: key add, substitution, rotate left.
    function automatic t_word round_mix(input t_word half, input t_word k);
        t_word t;
        t = sbox_layer(half + k);
        return {t[WordW-RotLeft-1:0], t[WordW-1:WordW-RotLeft]};
    endfunction

    // Key word used by a given round for encryption or decryption.
    function automatic logic [KeyIdxW-1:0] key_index(input int unsigned rnd,
                                                     input logic dec);
        logic [KeyIdxW-1:0] low;
        low = rnd[KeyIdxW-1:0];
        if (dec == CmdDecrypt) begin
            return (rnd < KeyWords) ? low : ~low;
        end
        return (rnd < Rounds - KeyWords) ? low : ~low;
    endfunction

endpackage

// File: rtl/mgm_if.sv
`timescale 1ns / 1ps
// Request channel interfaces for the Magma block cipher: input blocks and results.
// Depends on mgm_pkg for the payload widths.
interface mgm_in_if;
    logic                             valid;
    logic                             ready;
    logic                             command;
    logic [mgm_pkg::BlockW-1:0]       data_in;

    modport source (output valid, output command, output data_in, input ready);
    modport sink   (input valid, input command, input data_in, output ready);
endinterface

interface mgm_out_if;
    logic                             valid;
    logic                             ready;
    logic [mgm_pkg::BlockW-1:0]       data_out;

    modport source (output valid, output data_out, input ready);
    modport sink   (input valid, input data_out, output ready);
endinterface

// File: rtl/mgm_round_cell.sv
`timescale 1ns / 1ps
// One cell of the round chain: performs a single Feistel round and holds the result.
// Depends on mgm_pkg for the stage type and the round function.
module mgm_round_cell #(
    parameter int unsigned ROUND = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mgm_pkg::t_stage     i_prev,
    input  mgm_pkg::t_key       i_key,
    input  logic                i_next_ready,
    output logic                o_ready,
    output mgm_pkg::t_stage     o_stage
);

    logic                r_valid;
    logic                r_cmd;
    mgm_pkg::t_word      r_left;
    mgm_pkg::t_word      r_right;
    mgm_pkg::t_word      n_right;
    mgm_pkg::t_word      w_key;

    // The cell takes a new request when it is empty or its content moves on.
    assign o_ready = !r_valid || i_next_ready;

    // Pick the key word for this round by direction.
    always_comb begin
        w_key   = i_key[mgm_pkg::key_index(ROUND, i_prev.cmd)];
        n_right = i_prev.left ^ mgm_pkg::round_mix(i_prev.right, w_key);
    end

    // Control bit with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_prev.valid;
        end
    end

    // Payload: the halves trade places after the round.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_prev.valid) begin
            r_cmd   <= i_prev.cmd;
            r_left  <= i_prev.right;
            r_right <= n_right;
        end
    end

    assign o_stage = '{valid: r_valid, cmd: r_cmd, left: r_left, right: r_right};

endmodule

// File: rtl/magma_block_cipher.sv
`timescale 1ns / 1ps
// Top level of the Magma (GOST R 34.12-2015) 64-bit block cipher engine.
// Depends on mgm_pkg, mgm_if and mgm_round_cell.
//
// The engine takes one 64-bit block per clock cycle while its first cell is
// ready and returns the results in the order it accepts the blocks. Each block
// passes through a chain of 32 round cells, one Feistel round per cell, moving
// one cell per cycle; a stalled output holds only the cells that are full, so
// empty cells behind it still take requests. The key words are written through
// the configuration port (index 0..7; higher indexes are ignored) and must be
// written only while no block is in flight. Command 0 encrypts, 1 decrypts.
module magma_block_cipher (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mgm_pkg::CfgIdxW-1:0]     i_cfg_idx,
    input  logic [mgm_pkg::WordW-1:0]       i_cfg_data,
    mgm_in_if.sink                          i_blk,
    mgm_out_if.source                       o_blk
);

    mgm_pkg::t_key      r_key;
    mgm_pkg::t_stage    w_stage [mgm_pkg::Rounds+1];
    logic               w_ready [mgm_pkg::Rounds+1];

    // Key word registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < mgm_pkg::KeyWords; i++) begin
                r_key[i] <= '0;
            end
        end else if (i_cfg_we && (i_cfg_idx < mgm_pkg::CfgIdxW'(mgm_pkg::KeyWords))) begin
            r_key[i_cfg_idx[mgm_pkg::KeyIdxW-1:0]] <= i_cfg_data;
        end
    end

    // Entry to the chain: the upper half of the block is the left word.
    assign w_stage[0] = '{valid: i_blk.valid, cmd: i_blk.command,
                          left: i_blk.data_in[mgm_pkg::BlockW-1:mgm_pkg::WordW],
                          right: i_blk.data_in[mgm_pkg::WordW-1:0]};
    assign i_blk.ready = w_ready[0];

    // Chain of round cells.
    for (genvar g = 0; g < mgm_pkg::Rounds; g++) begin : g_cell
        mgm_round_cell #(
            .ROUND(g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_prev       (w_stage[g]),
            .i_key        (r_key),
            .i_next_ready (w_ready[g+1]),
            .o_ready      (w_ready[g]),
            .o_stage      (w_stage[g+1])
        );
    end

    // Result: halves traded back after the last round.
    assign w_ready[mgm_pkg::Rounds] = o_blk.ready;
    assign o_blk.valid    = w_stage[mgm_pkg::Rounds].valid;
    assign o_blk.data_out = {w_stage[mgm_pkg::Rounds].right, w_stage[mgm_pkg::Rounds].left};

endmodule
